/* hw/rtl/rtce_pkg.sv */
// Shared types and constants for the tag count estimator.
package rtce_pkg;

  localparam int unsigned CntW    = 11;
  localparam int unsigned GammaW  = 19;
  localparam int unsigned XW      = 20;
  localparam int unsigned ExpW    = 45;
  localparam int unsigned TermW   = 56;
  localparam int unsigned TermHalfW = 28;
  localparam int unsigned NumW    = 64;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned PassW   = 6;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned TermIdxW = 7;

  localparam logic [GammaW-1:0] GammaStart = 19'h20000;
  localparam logic [GammaW-1:0] GammaMax   = 19'h7FFFF;
  localparam logic [XW-1:0]     XMax       = 20'h80000;
  localparam logic [ExpW-1:0]   One44      = 45'h1_0000_0000_000 >> 0;
  localparam logic [TermIdxW-1:0] ExpTerms = 7'd80;

  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgLimit     = 1'b1;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_XDIV_START,
    OP_EXP_START,
    OP_TDIV_START,
    OP_EXP_STEP,
    OP_EXP_END,
    OP_FRAC_START,
    OP_FINISH,
    OP_SIZE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic tdiv_done;
    logic exp_last;
    logic zero_col;
    logic conv;
  } stat_t;

endpackage

/* hw/rtl/rtce_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module rtce_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* hw/rtl/rtce_datapath.sv */
// Datapath: counts, gamma, x, exponential series and the shared divider.
module rtce_datapath #(
  parameter int unsigned FrameSlotsMax = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtce_pkg::cmd_t                cmd_i,
  output rtce_pkg::stat_t               stat_o,
  input  logic [rtce_pkg::CntW-1:0]     success_slots_i,
  input  logic [rtce_pkg::CntW-1:0]     collision_slots_i,
  input  logic [rtce_pkg::CntW-1:0]     empty_slots_i,
  input  logic [rtce_pkg::ThrW-1:0]     threshold_i,
  output logic [rtce_pkg::SizeW-1:0]    size_o
);
  import rtce_pkg::*;

  localparam int unsigned LW = CntW + 2;

  function automatic logic [CntW-1:0] sat(input logic [CntW-1:0] v);
    if (32'(v) > FrameSlotsMax) return CntW'(FrameSlotsMax);
    return v;
  endfunction

  logic [CntW-1:0]   s_q, c_q;
  logic [LW-1:0]     len_q;
  logic [GammaW-1:0] g_q, g_d;
  logic [XW-1:0]     x_q;
  logic [TermW-1:0]  term_q, pos_q, neg_q;
  logic [ExpW-1:0]   e_q;
  logic [TermIdxW-1:0] n_q;
  logic              degen_q, conv_q;
  logic [SizeW-1:0]  size_q;

  logic              div_start, div_done;
  logic [NumW-1:0]   div_num, div_den, div_quo;
  logic              tdiv_start, tdiv_done;
  logic [TermW-1:0]  tdiv_quo;

  // Term times x, truncated to Q.44; the product is split in two halves.
  logic [TermHalfW+XW-1:0] ph, pl;
  logic [TermW-1:0]   tmul;
  logic [TermW-1:0]   ediff;
  logic [ExpW+XW-1:0] eprod;
  logic [ExpW-1:0]    prod44;
  logic [ExpW+XW-1:0] gnum;
  logic [GammaW+CntW-1:0] gc;
  logic [GammaW+CntW:0]   gcr;
  logic [NumW-1:0]    xnum;
  logic [GammaW-1:0]  ng;
  logic [GammaW-1:0]  delta;

  assign ph    = term_q[TermW-1:TermHalfW] * x_q;
  assign pl    = term_q[TermHalfW-1:0] * x_q;
  assign tmul  = TermW'({ph, 12'd0}) + {24'd0, pl[TermHalfW+XW-1:16]};
  assign ediff = pos_q - neg_q;
  assign eprod = ({{(XW-17){1'b0}}, 17'h10000} + x_q) * e_q;
  assign prod44 = eprod[ExpW+15:16];
  assign gnum = x_q * (One44 - e_q);
  assign gc  = g_q * c_q;
  assign gcr = {1'b0, gc} + 31'hFFFF;
  assign xnum = {{(NumW-GammaW-CntW){1'b0}}, gc} + {{(NumW-CntW-16){1'b0}}, s_q, 16'd0};

  assign div_start  = (cmd_i.op == OP_XDIV_START) || (cmd_i.op == OP_FRAC_START);
  assign tdiv_start = (cmd_i.op == OP_TDIV_START);

  rtce_div #(.W(NumW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i(div_num),
    .den_i(div_den),
    .done_o(div_done),
    .quo_o(div_quo)
  );

  // Each series term is divided by its index on a divider of its own.
  rtce_div #(.W(TermW)) u_tdiv (
    .clk_i, .rst_ni,
    .start_i(tdiv_start),
    .num_i(tmul),
    .den_i({{(TermW-TermIdxW){1'b0}}, n_q}),
    .done_o(tdiv_done),
    .quo_o(tdiv_quo)
  );

  always_comb begin
    if (cmd_i.op == OP_XDIV_START) begin
      div_num = xnum;
      div_den = {{(NumW-LW){1'b0}}, len_q};
    end else begin
      div_num = gnum[NumW-1:0];
      div_den = {{(NumW-ExpW){1'b0}}, One44 - prod44};
    end
  end

  always_comb begin
    ng = (div_quo > {{(NumW-GammaW){1'b0}}, GammaMax}) ? GammaMax : div_quo[GammaW-1:0];
    if (degen_q) ng = GammaStart;
    delta = (ng > g_q) ? ng - g_q : g_q - ng;
    g_d = ng;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degen_q    <= 1'b0;
      conv_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          degen_q <= 1'b0;
        end
        OP_FRAC_START: begin
          degen_q <= (prod44 >= One44);
        end
        OP_FINISH: begin
          conv_q  <= (delta <= {3'd0, threshold_i});
          degen_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        s_q   <= sat(success_slots_i);
        c_q   <= sat(collision_slots_i);
        len_q <= LW'(sat(success_slots_i)) + LW'(sat(collision_slots_i))
               + LW'(sat(empty_slots_i));
        g_q   <= GammaStart;
      end
      OP_EXP_START: begin
        x_q    <= (div_quo > {{(NumW-XW){1'b0}}, XMax}) ? XMax : div_quo[XW-1:0];
        term_q <= TermW'(One44);
        pos_q  <= TermW'(One44);
        neg_q  <= '0;
        n_q    <= TermIdxW'(1);
      end
      OP_EXP_STEP: begin
        term_q <= tdiv_quo;
        n_q    <= n_q + TermIdxW'(1);
        if (tdiv_quo != '0) begin
          if (n_q[0]) neg_q <= neg_q + tdiv_quo;
          else        pos_q <= pos_q + tdiv_quo;
        end
      end
      OP_EXP_END: begin
        e_q <= (pos_q <= neg_q) ? '0 :
               ((ediff > TermW'(One44)) ? One44 : ediff[ExpW-1:0]);
      end
      OP_FINISH: begin
        g_q <= g_d;
      end
      OP_SIZE: begin
        size_q <= (gcr[GammaW+CntW:16] > 15'd8191) ? 13'h1FFF : gcr[28:16];
      end
      default: begin
      end
    endcase
  end

  assign stat_o.div_done   = div_done;
  assign stat_o.tdiv_done  = tdiv_done;
  assign stat_o.exp_last   = (tdiv_quo == '0) || (n_q == ExpTerms);
  assign stat_o.zero_col   = (c_q == '0) || (len_q == '0);
  assign stat_o.conv       = conv_q;
  assign size_o            = size_q;
endmodule

/* hw/rtl/rtce_ctrl.sv */
// Controller: sequences the refinement passes and the final size.
module rtce_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rtce_pkg::PassW-1:0] limit_i,
  input  rtce_pkg::stat_t            stat_i,
  output rtce_pkg::cmd_t             cmd_o,
  output logic                       busy_o,
  output logic                       done_o,
  output logic                       conv_o,
  output logic [rtce_pkg::PassW-1:0] passes_o,
  output logic                       sel_size_o
);
  import rtce_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SCheck  = 4'd1;
  localparam logic [3:0] SXWait  = 4'd2;
  localparam logic [3:0] SExp    = 4'd3;
  localparam logic [3:0] SExpEnd = 4'd4;
  localparam logic [3:0] SFrac   = 4'd5;
  localparam logic [3:0] SGWait  = 4'd6;
  localparam logic [3:0] SDecide = 4'd7;
  localparam logic [3:0] SSize   = 4'd8;
  localparam logic [3:0] SOut    = 4'd9;
  localparam logic [3:0] SXStart = 4'd10;
  localparam logic [3:0] STWait  = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [PassW-1:0] pass_q, pass_d, lim;
  logic             zero_q, zero_d, done_q, done_d;

  assign lim = (limit_i == '0) ? PassW'(1) : limit_i;

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    zero_d    = zero_q;
    done_d    = 1'b0;
    cmd_o.op  = OP_NONE;
    case (state_q)
      SIdle: if (start_i) begin
        cmd_o.op = OP_LOAD;
        pass_d   = '0;
        state_d  = SCheck;
      end
      SCheck: begin
        if (stat_i.zero_col) begin
          zero_d  = 1'b1;
          state_d = SOut;
        end else begin
          zero_d  = 1'b0;
          state_d = SXStart;
        end
      end
      SXStart: begin
        cmd_o.op = OP_XDIV_START;
        pass_d   = pass_q + 1'b1;
        state_d  = SXWait;
      end
      SXWait: if (stat_i.div_done) begin
        cmd_o.op = OP_EXP_START;
        state_d  = SExp;
      end
      SExp: begin
        cmd_o.op = OP_TDIV_START;
        state_d  = STWait;
      end
      // The series ends at the first zero term or after the last allowed term.
      STWait: if (stat_i.tdiv_done) begin
        cmd_o.op = OP_EXP_STEP;
        state_d  = stat_i.exp_last ? SExpEnd : SExp;
      end
      SExpEnd: begin
        cmd_o.op = OP_EXP_END;
        state_d  = SFrac;
      end
      SFrac: begin
        cmd_o.op = OP_FRAC_START;
        state_d  = SGWait;
      end
      SGWait: begin
        if (stat_i.div_done) state_d = SDecide;
      end
      SDecide: begin
        cmd_o.op = OP_FINISH;
        state_d  = SSize;
      end
      SSize: begin
        if (stat_i.conv || pass_q >= lim) begin
          cmd_o.op = OP_SIZE;
          state_d  = SOut;
        end else begin
          state_d = SXStart;
        end
      end
      SOut: begin
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pass_q  <= '0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      zero_q  <= zero_d;
      done_q  <= done_d;
    end
  end

  assign busy_o     = (state_q != SIdle);
  assign done_o     = done_q;
  assign conv_o     = zero_q | stat_i.conv;
  assign passes_o   = zero_q ? '0 : pass_q;
  assign sel_size_o = ~zero_q;
endmodule

/* hw/rtl/rfid_tag_count_estimator.sv */
// Top level of the RFID tag count estimator.
// With no collisions the result follows the start without any refinement pass;
// otherwise each pass runs two divisions on the shared divider and up to 80
// series terms, each divided on the term divider, for at most 63 passes.
// Throughput: one word at a time; start is taken only while busy is low, which
// is already the case in the cycle of done_o. The receiver cannot stall.
// Reset clears the controller and sets threshold 66 and limit 32.
module rfid_tag_count_estimator #(
  parameter int unsigned FRAME_SLOTS_MAX = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [10:0]                success_slots_i,
  input  logic [10:0]                collision_slots_i,
  input  logic [10:0]                empty_slots_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [15:0]                cfg_data_i,
  output logic                       done_o,
  output logic [12:0]                next_frame_size_o,
  output logic                       converged_o,
  output logic [5:0]                 passes_used_o
);
  import rtce_pkg::*;

  logic [ThrW-1:0]  thr_q;
  logic [PassW-1:0] lim_q;
  cmd_t             cmd;
  stat_t            stat;
  logic [SizeW-1:0] size;
  logic             sel_size;
  logic             ctl_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd66;
      lim_q <= 6'd32;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgThreshold) thr_q <= cfg_data_i;
      else                           lim_q <= cfg_data_i[PassW-1:0];
    end
  end

  rtce_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start),
    .limit_i(lim_q),
    .stat_i(stat),
    .cmd_o(cmd),
    .busy_o(ctl_busy),
    .done_o(done_o),
    .conv_o(converged_o),
    .passes_o(passes_used_o),
    .sel_size_o(sel_size)
  );

  rtce_datapath #(.FrameSlotsMax(FRAME_SLOTS_MAX)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .success_slots_i,
    .collision_slots_i,
    .empty_slots_i,
    .threshold_i(thr_q),
    .size_o(size)
  );

  assign busy              = ctl_busy;
  assign next_frame_size_o = sel_size ? size : '0;
endmodule

/* hw/rtl/rtce_checker.sv */
// Port-level checker for the estimator, bound to the top level.
module rtce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [12:0] next_frame_size_o,
  input logic        converged_o,
  input logic [5:0]  passes_used_o
);
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_zero_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && passes_used_o == 6'd0) |-> (converged_o && next_frame_size_o == 13'd0))
    else $error("zero passes with nonzero result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

bind rfid_tag_count_estimator rtce_checker u_rtce_checker (.*);
